// File: hw/rtl/tcce_pkg.sv
package tcce_pkg;

  localparam int GLYPH_ROWS  = 16;
  localparam int GLYPH_COUNT = 256;
  localparam int TAB_STOP    = 4;

  localparam int LINE_BITS  = $clog2(GLYPH_ROWS);
  localparam int GLYPH_BITS = $clog2(GLYPH_COUNT);
  localparam int FONT_AW    = GLYPH_BITS + LINE_BITS;
  localparam int FONT_DEPTH = GLYPH_ROWS * GLYPH_COUNT;

  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS = CFG_IDX_W'(1);

  localparam logic [7:0] TEXT_COLS_RST = 8'd80;
  localparam logic [6:0] TEXT_ROWS_RST = 7'd25;

  localparam logic [1:0] MODE_CHAR   = 2'd0;
  localparam logic [1:0] MODE_CURSOR = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_FONT   = 2'd3;

  localparam logic [1:0] KIND_DRAW   = 2'd0;
  localparam logic [1:0] KIND_SCROLL = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef struct packed {
    logic [7:0] col;
    logic [6:0] row;
    logic       scroll;
    logic       draw;
  } curs_upd_t;

endpackage

// File: hw/rtl/tcce_font_ram.sv
module tcce_font_ram
  import tcce_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [FONT_AW-1:0] waddr,
  input  logic [7:0]         wdata,
  input  logic               re,
  input  logic [FONT_AW-1:0] raddr,
  output logic [7:0]         rdata
);

  logic [7:0] mem [FONT_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/tcce_cursor.sv
module tcce_cursor
  import tcce_pkg::*;
(
  input  logic [7:0] cur_col,
  input  logic [6:0] cur_row,
  input  logic [7:0] char_code,
  input  logic [7:0] text_cols,
  input  logic [6:0] text_rows,
  output curs_upd_t  upd
);

  logic [7:0] cols_eff;
  logic [6:0] rows_eff;
  logic [8:0] col9;
  logic [8:0] c;
  logic [7:0] r;
  logic       draw;

  always_comb begin
    cols_eff = (text_cols == 8'd0) ? 8'd1 : text_cols;
    rows_eff = (text_rows == 7'd0) ? 7'd1 : text_rows;
    col9     = {1'b0, cur_col};
    c        = col9;
    r        = {1'b0, cur_row};
    draw     = 1'b0;
    unique case (char_code)
      CH_LF: begin
        c = 9'd0;
        r = r + 8'd1;
      end
      CH_CR: begin
        c = 9'd0;
      end
      CH_HT: begin
        c = col9 - (col9 % 9'(TAB_STOP)) + 9'(TAB_STOP);
      end
      CH_BS: begin
        if (col9 != 9'd0) begin
          c = col9 - 9'd1;
        end
      end
      default: begin
        c    = col9 + 9'd1;
        draw = 1'b1;
      end
    endcase
    if (c >= {1'b0, cols_eff}) begin
      c = 9'd0;
      r = r + 8'd1;
    end
    upd.scroll = 1'b0;
    if (r >= {1'b0, rows_eff}) begin
      upd.scroll = 1'b1;
      r          = {1'b0, rows_eff - 7'd1};
    end
    upd.col  = c[7:0];
    upd.row  = r[6:0];
    upd.draw = draw;
  end

endmodule

// File: hw/rtl/text_console_cursor_engine.sv
// Channel  | Ports                                        | Direction
// request  | in_valid/in_ready, mode .. font_byte         | in
// result   | out_valid/out_ready, kind .. last            | out
// config   | cfg_valid/cfg_ready, cfg_index, cfg_data     | in
//
// A drawn character reads its 16 glyph rows, one per cycle from the font RAM
// read port while the result is not stalled, and gives a result per row, then
// a scroll result if the cursor passes the last row. Control codes give only
// a needed scroll result, clear a clear result; cursor moves and font loads none.
// Reset is synchronous; the font RAM is not cleared and must be loaded first.
// A stalled result holds the row pipeline; no new request is taken mid-glyph.
module text_console_cursor_engine
  import tcce_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_mode,
  input  logic [7:0]           in_char_code,
  input  logic [31:0]          in_paint_color,
  input  logic [7:0]           in_cursor_col_in,
  input  logic [6:0]           in_cursor_row_in,
  input  logic [11:0]          in_font_index,
  input  logic [7:0]           in_font_byte,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_cell_col,
  output logic [6:0]           out_cell_row,
  output logic [3:0]           out_glyph_line,
  output logic [7:0]           out_row_bits,
  output logic [31:0]          out_fg_color,
  output logic [31:0]          out_bg_color,
  output logic                 out_last,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DRAW   = 2'd1;
  localparam logic [1:0] ST_SCROLL = 2'd2;
  localparam logic [1:0] ST_CLEAR  = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [7:0]           text_cols_r;
  logic [6:0]           text_rows_r;
  logic [7:0]           cursor_col_r;
  logic [6:0]           cursor_row_r;
  logic [31:0]          background_r;

  logic [7:0]           code_r;
  logic [31:0]          paint_r;
  logic [7:0]           draw_col_r;
  logic [6:0]           draw_row_r;
  logic                 scroll_r;
  logic [LINE_BITS:0]   iss_cnt_r;
  logic [LINE_BITS-1:0] rd_line_r;
  logic                 rd_valid_r;
  logic                 out_valid_r;

  logic                 in_fire;
  logic                 out_free;
  logic                 issue;
  logic                 load;
  logic                 load_last;
  logic [7:0]           cols_eff;
  logic [6:0]           rows_eff;
  logic                 font_we;
  logic [FONT_AW-1:0]   font_raddr;
  logic [7:0]           font_rdata;
  curs_upd_t            upd;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign load      = (state_r == ST_DRAW) && rd_valid_r && out_free;
  assign load_last = load && (rd_line_r == LINE_BITS'(GLYPH_ROWS - 1));
  assign issue     = (state_r == ST_DRAW) && (iss_cnt_r < (LINE_BITS + 1)'(GLYPH_ROWS))
                     && (!rd_valid_r || load);
  assign cols_eff  = (text_cols_r == 8'd0) ? 8'd1 : text_cols_r;
  assign rows_eff  = (text_rows_r == 7'd0) ? 7'd1 : text_rows_r;
  assign font_we   = in_fire && (in_mode == MODE_FONT)
                     && ({2'b00, in_font_index} < 14'(FONT_DEPTH));
  assign font_raddr = {code_r[GLYPH_BITS-1:0], iss_cnt_r[LINE_BITS-1:0]};

  tcce_cursor u_cursor (
    .cur_col   (cursor_col_r),
    .cur_row   (cursor_row_r),
    .char_code (in_char_code),
    .text_cols (text_cols_r),
    .text_rows (text_rows_r),
    .upd       (upd)
  );

  tcce_font_ram u_font (
    .clk   (clk),
    .we    (font_we),
    .waddr (in_font_index[FONT_AW-1:0]),
    .wdata (in_font_byte),
    .re    (issue),
    .raddr (font_raddr),
    .rdata (font_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_mode == MODE_CLEAR) begin
            state_nxt = ST_CLEAR;
          end else if (in_mode == MODE_CHAR) begin
            if (upd.draw) begin
              state_nxt = ST_DRAW;
            end else if (upd.scroll) begin
              state_nxt = ST_SCROLL;
            end
          end
        end
      end
      ST_DRAW: begin
        if (load_last) begin
          state_nxt = scroll_r ? ST_SCROLL : ST_IDLE;
        end
      end
      ST_SCROLL, ST_CLEAR: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      text_cols_r  <= TEXT_COLS_RST;
      text_rows_r  <= TEXT_ROWS_RST;
      cursor_col_r <= 8'd0;
      cursor_row_r <= 7'd0;
      background_r <= 32'd0;
      rd_valid_r   <= 1'b0;
      iss_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TEXT_COLS) begin
          text_cols_r <= cfg_data;
        end else if (cfg_index == REG_TEXT_ROWS) begin
          text_rows_r <= cfg_data[6:0];
        end
      end
      if (in_fire) begin
        unique case (in_mode)
          MODE_CHAR: begin
            cursor_col_r <= upd.col;
            cursor_row_r <= upd.row;
          end
          MODE_CURSOR: begin
            if (in_cursor_col_in < cols_eff) begin
              cursor_col_r <= in_cursor_col_in;
            end
            if (in_cursor_row_in < rows_eff) begin
              cursor_row_r <= in_cursor_row_in;
            end
          end
          MODE_CLEAR: begin
            background_r <= in_paint_color;
            cursor_col_r <= 8'd0;
            cursor_row_r <= 7'd0;
          end
          MODE_FONT: begin
          end
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        iss_cnt_r  <= '0;
        rd_valid_r <= 1'b0;
      end else if (issue) begin
        iss_cnt_r  <= iss_cnt_r + (LINE_BITS + 1)'(1);
        rd_valid_r <= 1'b1;
      end else if (load) begin
        rd_valid_r <= 1'b0;
      end
      if (load || ((state_r == ST_SCROLL || state_r == ST_CLEAR) && out_free)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      code_r     <= in_char_code;
      paint_r    <= in_paint_color;
      draw_col_r <= cursor_col_r;
      draw_row_r <= cursor_row_r;
      scroll_r   <= upd.scroll;
    end
    if (issue) begin
      rd_line_r <= iss_cnt_r[LINE_BITS-1:0];
    end
    if (load) begin
      out_kind       <= KIND_DRAW;
      out_cell_col   <= draw_col_r;
      out_cell_row   <= draw_row_r;
      out_glyph_line <= 4'(rd_line_r);
      out_row_bits   <= font_rdata;
      out_fg_color   <= paint_r;
      out_bg_color   <= background_r;
      out_last       <= load_last && !scroll_r;
    end else if ((state_r == ST_SCROLL || state_r == ST_CLEAR) && out_free) begin
      out_kind       <= (state_r == ST_SCROLL) ? KIND_SCROLL : KIND_CLEAR;
      out_cell_col   <= 8'd0;
      out_cell_row   <= 7'd0;
      out_glyph_line <= 4'd0;
      out_row_bits   <= 8'd0;
      out_fg_color   <= 32'd0;
      out_bg_color   <= background_r;
      out_last       <= 1'b1;
    end
  end

endmodule
